// ===== hdl/bors_pkg.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered region set package
// Shared constants, request and outcome codes, and the cell command type.
// ----------------------------------------------------------------------------
package bors_pkg;

  localparam int MAX_ENTRIES = 16;
  localparam int ID_BITS     = 16;
  localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

  localparam int REQ_W   = 2;
  localparam int RID_W   = 16;
  localparam int CNTO_W  = 5;
  localparam int OUT_W   = 1 + 3 + CNTO_W;
  localparam int OUT_TDATA_W = ((OUT_W + 7) / 8) * 8;

  typedef enum logic [REQ_W-1:0] {
    REQ_INSERT = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_QUERY  = 2'd2
  } req_e;

  typedef enum logic [2:0] {
    OUT_ADDED       = 3'd0,
    OUT_PRESENT     = 3'd1,
    OUT_FULL        = 3'd2,
    OUT_INVALID     = 3'd3,
    OUT_REMOVED     = 3'd4,
    OUT_NOT_FOUND   = 3'd5,
    OUT_MEMBER      = 3'd6,
    OUT_NOT_MEMBER  = 3'd7
  } outcome_e;

  typedef enum logic {
    S_IDLE = 1'b0,
    S_EXEC = 1'b1
  } state_e;

  // Command broadcast to every cell of the chain.
  typedef struct packed {
    logic               insert;
    logic               remove;
    logic [ID_BITS-1:0] id;
  } cell_cmd_t;

endpackage

// ===== hdl/bors_cell.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered region set cell
// Holds one entry, compares it with the broadcast id and loads from the
// request or from its upper neighbor.
// ----------------------------------------------------------------------------
module bors_cell
  import bors_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cell_cmd_t          cmd_i,
  input  logic               prev_used_i,
  input  logic [ID_BITS-1:0] next_entry_i,
  input  logic               seen_i,
  output logic [ID_BITS-1:0] entry_o,
  output logic               used_o,
  output logic               hit_o,
  output logic               seen_o
);

  logic [ID_BITS-1:0] entry_q, entry_d;

  // Held ids are nonzero, so an empty slot never counts as a match.
  assign used_o  = (entry_q != '0);
  assign hit_o   = used_o && (entry_q == cmd_i.id);
  assign seen_o  = seen_i | hit_o;
  assign entry_o = entry_q;

  always_comb begin
    entry_d = entry_q;
    if (cmd_i.insert && !used_o && prev_used_i) begin
      entry_d = cmd_i.id;
    end else if (cmd_i.remove && seen_o) begin
      entry_d = next_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      entry_q <= '0;
    end else begin
      entry_q <= entry_d;
    end
  end

endmodule

// ===== hdl/bounded_ordered_region_set_unit.sv =====
// A request is registered while the block is idle, and the cell chain compares
// and shifts in the execute step, where the result is registered.
// No new request is taken until the execute step of the last one has ended;
// the input is ready only in the idle step.
// A stalled result holds the chain in its execute step until it is taken.
// Reset clears every cell and the entry count at once; no clearing pass.
// ----------------------------------------------------------------------------
// Bounded ordered region set unit
// Insertion-ordered set of nonzero ids kept in a chain of cells.
// ----------------------------------------------------------------------------
module bounded_ordered_region_set_unit
  import bors_pkg::*;
(
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [RID_W-1:0]       s_axis_tdata,  // [15:0] region_id
  input  logic [REQ_W-1:0]       s_axis_tuser,  // [1:0] req_type
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [0] ok, [3:1] outcome,
                                                // [8:4] count_after, rest zero
);

  state_e             state_q, state_d;
  logic [REQ_W-1:0]   kind_q;
  logic [ID_BITS-1:0] id_q;
  logic [CNT_W-1:0]   count_q, count_d;

  logic               out_valid_q, out_valid_d;
  logic               ok_q, ok_d;
  outcome_e           outcome_q, outcome_d;
  logic [CNTO_W-1:0]  cnt_out_q, cnt_out_d;

  logic               commit;
  logic               hit_any;
  logic               full;
  logic               do_insert, do_remove;
  cell_cmd_t          cmd;

  logic [ID_BITS-1:0]   entry [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] used;
  logic [MAX_ENTRIES-1:0] hit;
  logic [MAX_ENTRIES:0]   seen;

  assign s_axis_tready = (state_q == S_IDLE);
  assign commit        = (state_q == S_EXEC) && (!out_valid_q || m_axis_tready);
  assign hit_any       = |hit;
  assign full          = (count_q == CNT_W'(MAX_ENTRIES));
  assign seen[0]       = 1'b0;

  assign cmd.insert = do_insert;
  assign cmd.remove = do_remove;
  assign cmd.id     = id_q;

  for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
    logic               prev_used;
    logic [ID_BITS-1:0] next_entry;

    if (i == 0) begin : g_first
      assign prev_used = 1'b1;
    end else begin : g_mid
      assign prev_used = used[i-1];
    end

    if (i == MAX_ENTRIES - 1) begin : g_last
      assign next_entry = '0;
    end else begin : g_body
      assign next_entry = entry[i+1];
    end

    bors_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .cmd_i        (cmd),
      .prev_used_i  (prev_used),
      .next_entry_i (next_entry),
      .seen_i       (seen[i]),
      .entry_o      (entry[i]),
      .used_o       (used[i]),
      .hit_o        (hit[i]),
      .seen_o       (seen[i+1])
    );
  end

  // Request decode and result formation in the execute step.
  always_comb begin
    do_insert = 1'b0;
    do_remove = 1'b0;
    ok_d      = ok_q;
    outcome_d = outcome_q;
    count_d   = count_q;
    if (commit) begin
      unique case (kind_q)
        REQ_INSERT: begin
          if (id_q == '0) begin
            ok_d      = 1'b0;
            outcome_d = OUT_INVALID;
          end else if (hit_any) begin
            ok_d      = 1'b1;
            outcome_d = OUT_PRESENT;
          end else if (full) begin
            ok_d      = 1'b0;
            outcome_d = OUT_FULL;
          end else begin
            do_insert = 1'b1;
            ok_d      = 1'b1;
            outcome_d = OUT_ADDED;
            count_d   = count_q + CNT_W'(1);
          end
        end
        REQ_REMOVE: begin
          if (hit_any) begin
            do_remove = 1'b1;
            ok_d      = 1'b1;
            outcome_d = OUT_REMOVED;
            count_d   = count_q - CNT_W'(1);
          end else begin
            ok_d      = 1'b0;
            outcome_d = OUT_NOT_FOUND;
          end
        end
        default: begin
          ok_d      = hit_any;
          outcome_d = hit_any ? OUT_MEMBER : OUT_NOT_MEMBER;
        end
      endcase
    end
    cnt_out_d = commit ? CNTO_W'(count_d) : cnt_out_q;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      kind_q <= s_axis_tuser;
      id_q   <= ID_BITS'(s_axis_tdata);
    end
    ok_q      <= ok_d;
    outcome_q <= outcome_d;
    cnt_out_q <= cnt_out_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = OUT_TDATA_W'({cnt_out_q, outcome_q, ok_q});

endmodule

// ===== hdl/bors_checker.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered region set checker
// Port-level assertions on the request and result streams.
// ----------------------------------------------------------------------------
module bors_checker
  import bors_pkg::*;
(
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   s_axis_tvalid,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  // The success flag must agree with the outcome code.
  a_ok_matches_outcome: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[0] ==
      ((m_axis_tdata[3:1] == OUT_ADDED) || (m_axis_tdata[3:1] == OUT_PRESENT) ||
       (m_axis_tdata[3:1] == OUT_REMOVED) || (m_axis_tdata[3:1] == OUT_MEMBER))))
    else $error("ok flag disagrees with outcome");

  // The reported count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[8:4] <= CNTO_W'(MAX_ENTRIES)))
    else $error("count above capacity");

  // The input is not ready while a taken request executes.
  a_no_back_to_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("request taken while previous one executes");

  // A stalled result holds its value.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("stalled result changed");

endmodule

bind bounded_ordered_region_set_unit bors_checker u_bors_checker (.*);

// ===== verif/bounded_ordered_region_set_unit_test.sv =====
// ----------------------------------------------------------------------------
// Bounded ordered region set unit regression
// Drives insert, remove and query requests into the stream input with random
// gaps and back-pressure. A tracker keeps its own copy of the ordered id list,
// predicts every answer, and compares the answers field by field in order.
// ----------------------------------------------------------------------------
module bounded_ordered_region_set_unit_test;
  import bors_pkg::*;

  // The request type field has one code that the block answers like a query.
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
  localparam int POOL_SIZE  = 24;
  localparam int PHASES     = 8;
  localparam int PHASE_LEN  = 106;

  typedef struct {
    logic                ok;
    outcome_e            outcome;
    logic [CNTO_W-1:0]   count_after;
  } region_answer_t;

  class region_set_tracker;
    logic [ID_BITS-1:0] held_ids[MAX_ENTRIES];
    int unsigned        held_count;
    region_answer_t     answers_due[$];
    int unsigned        fail_count;

    function new();
      foreach (held_ids[i]) held_ids[i] = '0;
      held_count = 0;
      fail_count = 0;
    endfunction

    function int find_id(logic [ID_BITS-1:0] key);
      for (int i = 0; i < held_count; i++) begin
        if (held_ids[i] == key) return i;
      end
      return -1;
    endfunction

    function void note_request(logic [REQ_W-1:0] kind, logic [RID_W-1:0] region_id);
      logic [ID_BITS-1:0] key;
      int                 slot;
      region_answer_t     answer;
      key = region_id[ID_BITS-1:0];
      slot = (key == '0) ? -1 : find_id(key);
      answer.ok = 1'b0;
      case (kind)
        REQ_INSERT: begin
          if (key == '0) begin
            answer.outcome = OUT_INVALID;
          end else if (slot >= 0) begin
            answer.ok      = 1'b1;
            answer.outcome = OUT_PRESENT;
          end else if (held_count >= MAX_ENTRIES) begin
            answer.outcome = OUT_FULL;
          end else begin
            held_ids[held_count] = key;
            held_count++;
            answer.ok      = 1'b1;
            answer.outcome = OUT_ADDED;
          end
        end
        REQ_REMOVE: begin
          if (slot >= 0) begin
            // Later entries move down one slot and the freed tail slot is cleared.
            for (int j = slot + 1; j < held_count; j++) held_ids[j-1] = held_ids[j];
            held_count--;
            held_ids[held_count] = '0;
            answer.ok      = 1'b1;
            answer.outcome = OUT_REMOVED;
          end else begin
            answer.outcome = OUT_NOT_FOUND;
          end
        end
        default: begin
          answer.ok      = (slot >= 0);
          answer.outcome = (slot >= 0) ? OUT_MEMBER : OUT_NOT_MEMBER;
        end
      endcase
      answer.count_after = held_count[CNTO_W-1:0];
      answers_due = {answers_due, answer};
    endfunction

    task report(string what);
      $display("%0t mismatch: %s", $time, what);
      fail_count++;
    endtask

    task check_answer(logic [OUT_TDATA_W-1:0] word);
      region_answer_t    want;
      outcome_e          got_outcome;
      logic [CNTO_W-1:0] got_count;
      got_outcome = outcome_e'(word[3:1]);
      got_count   = word[4 +: CNTO_W];
      if (answers_due.size() == 0) begin
        report($sformatf("answer %h arrived with no request pending", word));
      end else begin
        want = answers_due.pop_front();
        if (word[0] !== want.ok)
          report($sformatf("ok got %b want %b", word[0], want.ok));
        if (got_outcome !== want.outcome)
          report($sformatf("outcome got %s want %s", got_outcome.name(), want.outcome.name()));
        if (got_count !== want.count_after)
          report($sformatf("count_after got %0d want %0d", got_count, want.count_after));
        if (word[OUT_TDATA_W-1:OUT_W] !== '0)
          report($sformatf("padding bits not zero in %h", word));
      end
    endtask
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [RID_W-1:0]       s_axis_tdata;
  logic [REQ_W-1:0]       s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_TDATA_W-1:0] m_axis_tdata;

  region_set_tracker region_set = new();
  logic [RID_W-1:0]  id_pool[POOL_SIZE];
  bit                steady;

  bounded_ordered_region_set_unit u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic int unsigned draw_gap();
    return steady ? 0 : $urandom_range(0, 5);
  endfunction

  // Leaves tvalid high after the transaction so a back-to-back request
  // needs no second assignment in the same step.
  task automatic send_request(logic [REQ_W-1:0] kind, logic [RID_W-1:0] region_id);
    int unsigned gap;
    gap = draw_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= kind;
    s_axis_tdata  <= region_id;
    do @(posedge clk_i); while (!s_axis_tready);
    region_set.note_request(kind, region_id);
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (region_set.answers_due.size() != 0) @(posedge clk_i);
  endtask

  task automatic send_random_request(int unsigned ins_pct, int unsigned rem_pct);
    int unsigned      pick;
    logic [REQ_W-1:0] kind;
    logic [RID_W-1:0] region_id;
    pick = $urandom_range(0, 99);
    if (pick < ins_pct) kind = REQ_INSERT;
    else if (pick < ins_pct + rem_pct) kind = REQ_REMOVE;
    else if (pick < 97) kind = REQ_QUERY;
    else kind = REQ_UNUSED;
    pick = $urandom_range(0, 99);
    // A small pool keeps hits, a full list and an empty list all common.
    if (pick < 85) region_id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
    else if (pick < 95) region_id = RID_W'($urandom);
    else region_id = '0;
    send_request(kind, region_id);
  endtask

  // Result side: one random stall before each transaction.
  initial begin
    int unsigned gap;
    wait (rst_ni === 1'b1);
    forever begin
      gap = draw_gap();
      if (gap > 0) begin
        m_axis_tready <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      region_set.check_answer(m_axis_tdata);
    end
  end

  initial begin
    #2_000_000;
    $display("bounded_ordered_region_set_unit regression: fail");
    $finish;
  end

  initial begin
    int unsigned ins_pct;
    int unsigned rem_pct;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = REQ_INSERT;
    m_axis_tready = 1'b0;
    steady        = 1'b0;
    foreach (id_pool[i]) id_pool[i] = RID_W'($urandom_range(1, 16'hFFFF));
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty list, invalid id, duplicate insert and the unused request type.
    send_request(REQ_QUERY,  16'h0005);
    send_request(REQ_INSERT, 16'h0000);
    send_request(REQ_INSERT, 16'hFFFF);
    send_request(REQ_INSERT, 16'hFFFF);
    send_request(REQ_QUERY,  16'hFFFF);
    send_request(REQ_QUERY,  16'h0000);
    send_request(REQ_REMOVE, 16'h0000);
    send_request(REQ_UNUSED, 16'hFFFF);
    send_request(REQ_UNUSED, 16'h0000);
    // Fill to capacity, then probe the order of the insert checks.
    for (int k = 0; k < MAX_ENTRIES - 1; k++) send_request(REQ_INSERT, 16'h0001 << k);
    send_request(REQ_INSERT, 16'h8000);
    send_request(REQ_INSERT, 16'h0001);
    send_request(REQ_INSERT, 16'h0000);
    // Remove the head, which shifts every entry, and then the tail.
    send_request(REQ_REMOVE, 16'hFFFF);
    send_request(REQ_REMOVE, 16'h4000);
    wait_drained();

    for (int phase = 0; phase < PHASES; phase++) begin
      steady  = (phase % 3 == 2);
      ins_pct = (phase % 2 == 0) ? 60 : 25;
      rem_pct = (phase % 2 == 0) ? 20 : 55;
      if (phase == PHASES / 2) wait_drained();
      for (int n = 0; n < PHASE_LEN; n++) send_random_request(ins_pct, rem_pct);
    end

    wait_drained();
    repeat (8) @(posedge clk_i);
    if (region_set.fail_count == 0) begin
      $display("bounded_ordered_region_set_unit regression: pass");
    end else begin
      $display("bounded_ordered_region_set_unit regression: fail");
    end
    $finish;
  end

endmodule
